FILE: design/ctt_pkg.sv
// shared constants, codes and types for the countdown timer table
`default_nettype none
package ctt_pkg;

    // table geometry
    localparam int SLOTS      = 8;
    localparam int COUNT_BITS = 16;
    localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ADDR_W     = $clog2(SLOTS + 1);

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // port field widths
    localparam int CMD_W    = 2;
    localparam int ID_W     = 8;
    localparam int LOAD_W   = 16;
    localparam int STATUS_W = 2;
    localparam int REM_W    = 16;
    localparam int MASK_W   = 8;

    // command codes on the input port
    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // status codes on the output port
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    // classified operation
    typedef enum logic [1:0] {
        OP_START,
        OP_TICK,
        OP_READ,
        OP_NOP
    } t_op;

    // one queued command
    typedef struct packed {
        t_op                   op;
        logic [ID_W-1:0]       timer_id;
        logic [COUNT_BITS-1:0] load;
    } t_cmd;

    // head of the command queue as seen by the back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_queue_out;

    // back end sequencer states
    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_FINISH
    } t_back_state;

endpackage
`default_nettype wire

FILE: design/ctt_front.sv
// front end: takes items, classifies the command and queues it for the back end
`default_nettype none
module ctt_front import ctt_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [CMD_W-1:0]  i_command,
    input  wire logic [ID_W-1:0]   i_timer_id,
    input  wire logic [LOAD_W-1:0] i_load_value,
    input  wire logic              i_pop,
    output t_queue_out             o_q
);

    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    t_cmd              r_q [QDEPTH];
    t_cmd              cls_cmd;
    logic              push;
    logic              pop;

    // classify the incoming command
    always_comb begin
        cls_cmd.timer_id = i_timer_id;
        cls_cmd.load     = COUNT_BITS'(i_load_value);
        unique case (i_command)
            CMD_START: cls_cmd.op = OP_START;
            CMD_TICK:  cls_cmd.op = OP_TICK;
            CMD_READ:  cls_cmd.op = OP_READ;
            default:   cls_cmd.op = OP_NOP;
        endcase
    end

    // queue handshakes
    assign o_in_stall = (r_count == QCNT_W'(QDEPTH));
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_pop && (r_count != '0);
    assign o_q.valid  = (r_count != '0);
    assign o_q.cmd    = r_q[r_rd_ptr];

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cls_cmd;
        end
    end

endmodule
`default_nettype wire

FILE: design/ctt_back.sv
// back end: scans the slot table one slot per cycle and posts the result item
`default_nettype none
module ctt_back import ctt_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_queue_out           i_q,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [STATUS_W-1:0]       o_status,
    output logic [REM_W-1:0]          o_remaining,
    output logic [MASK_W-1:0]         o_expired_mask
);

    t_back_state           r_state;
    t_back_state           n_state;
    t_cmd                  r_cmd;
    logic [ADDR_W-1:0]     r_addr;
    logic                  r_rd_vld;
    logic [IDX_W-1:0]      r_rd_idx;
    logic [ID_W-1:0]       r_rd_id;
    logic [COUNT_BITS-1:0] r_rd_cnt;
    logic [SLOTS-1:0]      r_slot_valid;
    logic [ID_W-1:0]       mem_id  [SLOTS];
    logic [COUNT_BITS-1:0] mem_cnt [SLOTS];
    logic                  r_hit;
    logic [IDX_W-1:0]      r_hit_idx;
    logic [COUNT_BITS-1:0] r_hit_cnt;
    logic                  r_free;
    logic [IDX_W-1:0]      r_free_idx;
    logic [SLOTS-1:0]      r_mask;
    logic                  r_o_valid;
    logic [STATUS_W-1:0]   r_o_status;
    logic [REM_W-1:0]      r_o_rem;
    logic [MASK_W-1:0]     r_o_mask;
    logic [STATUS_W-1:0]   n_o_status;
    logic [REM_W-1:0]      n_o_rem;
    logic [MASK_W-1:0]     n_o_mask;

    logic                  scan_more;
    logic                  out_free;
    logic                  take;
    logic                  issue;
    logic                  eval;
    logic                  finish;
    logic                  ev_valid;
    logic                  ev_match;
    logic [COUNT_BITS-1:0] ev_dec;
    logic                  ev_expire;
    logic                  ev_write_dec;
    logic                  fin_cnt_write;
    logic                  fin_id_write;
    logic                  wr_cnt_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [COUNT_BITS-1:0] wr_cnt;

    assign scan_more = (r_addr < ADDR_W'(SLOTS));
    assign out_free  = !r_o_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (i_q.valid) begin
                    n_state = (i_q.cmd.op == OP_NOP) ? B_FINISH : B_SCAN;
                end
            end
            B_SCAN: begin
                if (!scan_more && !r_rd_vld) begin
                    n_state = B_FINISH;
                end
            end
            B_FINISH: begin
                if (out_free) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // sequencer controls
    always_comb begin
        take   = 1'b0;
        issue  = 1'b0;
        eval   = 1'b0;
        finish = 1'b0;
        unique case (r_state)
            B_IDLE:   take   = i_q.valid;
            B_SCAN: begin
                issue = scan_more;
                eval  = r_rd_vld;
            end
            B_FINISH: finish = out_free;
            default: begin
                take = 1'b0;
            end
        endcase
    end

    assign o_pop = take;

    // per slot evaluation on the registered read data
    assign ev_valid     = r_slot_valid[r_rd_idx];
    assign ev_match     = ev_valid && (r_rd_id == r_cmd.timer_id);
    assign ev_dec       = r_rd_cnt - COUNT_BITS'(1);
    assign ev_expire    = eval && (r_cmd.op == OP_TICK) && ev_valid &&
                          ((r_rd_cnt == '0) || (ev_dec == '0));
    assign ev_write_dec = eval && (r_cmd.op == OP_TICK) && ev_valid && (r_rd_cnt != '0);

    // start writes at the end of the scan
    assign fin_cnt_write = finish && (r_cmd.op == OP_START) && (r_hit || r_free);
    assign fin_id_write  = finish && (r_cmd.op == OP_START) && !r_hit && r_free;

    // single write port of the count memory
    assign wr_cnt_en = ev_write_dec || fin_cnt_write;
    assign wr_addr   = eval ? r_rd_idx : (r_hit ? r_hit_idx : r_free_idx);
    assign wr_cnt    = eval ? ev_dec : r_cmd.load;

    // result fields
    always_comb begin
        n_o_status = ST_OK;
        n_o_rem    = '0;
        n_o_mask   = '0;
        unique case (r_cmd.op)
            OP_START: begin
                if (!r_hit && !r_free) begin
                    n_o_status = ST_FULL;
                end
            end
            OP_TICK:  n_o_mask = MASK_W'(r_mask);
            OP_READ: begin
                if (r_hit) begin
                    n_o_rem = REM_W'(r_hit_cnt);
                end else begin
                    n_o_status = ST_NOT_FOUND;
                end
            end
            default: n_o_status = ST_OK;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_IDLE;
            r_rd_vld     <= 1'b0;
            r_slot_valid <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= issue;
            if (ev_expire) begin
                r_slot_valid[r_rd_idx] <= 1'b0;
            end
            if (fin_id_write) begin
                r_slot_valid[r_free_idx] <= 1'b1;
            end
            if (finish) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd  <= i_q.cmd;
            r_addr <= '0;
            r_hit  <= 1'b0;
            r_free <= 1'b0;
            r_mask <= '0;
        end else begin
            if (issue) begin
                r_addr   <= r_addr + 1'b1;
                r_rd_idx <= r_addr[IDX_W-1:0];
            end
            if (eval && ev_match && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_rd_idx;
                r_hit_cnt <= r_rd_cnt;
            end
            if (eval && !ev_valid && !r_free) begin
                r_free     <= 1'b1;
                r_free_idx <= r_rd_idx;
            end
            if (ev_expire) begin
                r_mask[r_rd_idx] <= 1'b1;
            end
        end
    end

    // slot memories with registered read
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_id  <= mem_id[r_addr[IDX_W-1:0]];
            r_rd_cnt <= mem_cnt[r_addr[IDX_W-1:0]];
        end
        if (wr_cnt_en) begin
            mem_cnt[wr_addr] <= wr_cnt;
        end
        if (fin_id_write) begin
            mem_id[r_free_idx] <= r_cmd.timer_id;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_o_status <= n_o_status;
            r_o_rem    <= n_o_rem;
            r_o_mask   <= n_o_mask;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_status       = r_o_status;
    assign o_remaining    = r_o_rem;
    assign o_expired_mask = r_o_mask;

`ifndef SYNTHESIS
    a_rd_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> r_state == B_SCAN)
        else $error("slot read data outside of a scan");
    a_addr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_SCAN |-> r_addr <= ADDR_W'(SLOTS))
        else $error("scan address past the table");
    a_mask_only_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_mask != '0) |-> (r_o_status == ST_OK && r_o_rem == '0))
        else $error("expired mask on a non tick result");
    a_take_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> (r_state == B_SCAN || r_state == B_FINISH))
        else $error("item taken without starting work");
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> r_slot_valid == '0)
        else $error("slots not freed by reset");
`endif

endmodule
`default_nettype wire

FILE: design/countdown_timer_table_core.sv
// top level of the countdown timer table: front end, command queue and slot scanner
//
//   channel | valid       | stall       | fields
//   --------+-------------+-------------+------------------------------------------
//   in      | i_in_valid  | o_in_stall  | i_command, i_timer_id, i_load_value
//   out     | o_out_valid | i_out_stall | o_status, o_remaining, o_expired_mask
//
// each item goes through the back end in order: it is taken from the queue, then the
// slot memory with registered read and one write port is walked (one issue per slot,
// then the last read data is evaluated, then the read pipe is seen empty), and the
// result is posted, waiting while an earlier result is held by output stall; an unused command skips the walk
// reset is synchronous and active low; it frees all slots at once, no clearing pass
// the front queue holds two items, so input is taken while the back end works
// or while a finished result waits on output stall
`default_nettype none
module countdown_timer_table_core import ctt_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [CMD_W-1:0]     i_command,
    input  wire logic [ID_W-1:0]      i_timer_id,
    input  wire logic [LOAD_W-1:0]    i_load_value,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [STATUS_W-1:0]       o_status,
    output logic [REM_W-1:0]          o_remaining,
    output logic [MASK_W-1:0]         o_expired_mask
);

    t_queue_out q_head;
    logic       q_pop;

    // accept and classify
    ctt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_timer_id   (i_timer_id),
        .i_load_value (i_load_value),
        .i_pop        (q_pop),
        .o_q          (q_head)
    );

    // execute against the slot table
    ctt_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q            (q_head),
        .o_pop          (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_remaining    (o_remaining),
        .o_expired_mask (o_expired_mask)
    );

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
// self-checking testbench for the countdown timer table: directed table, then random traffic
`timescale 1ns / 1ps
module tb_top;
    import ctt_pkg::*;

    // spare command code, the block must answer it with an empty ok reply
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 1426;
    localparam int PHASE_HOLD   = 300;
    localparam int PHASE_DRAIN  = 700;
    localparam int PHASE_QUIET  = 1176;
    localparam int LONG_HOLD    = 150;
    localparam int SETTLE       = 40;
    localparam int SCRIPT_LEN   = 24;

    // one reply of the block
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [REM_W-1:0]    remaining;
        logic [MASK_W-1:0]   expired;
    } t_timer_reply;

    // one row of the directed table; known marks a reply typed in by hand
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ID_W-1:0]   id;
        logic [LOAD_W-1:0] load;
        logic              known;
        t_timer_reply      reply;
    } t_script_row;

    localparam t_script_row SCRIPT [SCRIPT_LEN] = '{
        '{CMD_READ,   8'd0,   16'd0,      1'b1, '{ST_NOT_FOUND, 16'd0, 8'h00}},
        '{CMD_TICK,   8'd0,   16'd0,      1'b1, '{ST_OK, 16'd0, 8'h00}},
        '{CMD_UNUSED, 8'd0,   16'd0,      1'b1, '{ST_OK, 16'd0, 8'h00}},
        '{CMD_START,  8'd0,   16'd0,      1'b1, '{ST_OK, 16'd0, 8'h00}},
        '{CMD_READ,   8'd0,   16'd0,      1'b1, '{ST_OK, 16'd0, 8'h00}},
        '{CMD_TICK,   8'd0,   16'd0,      1'b1, '{ST_OK, 16'd0, 8'h01}},
        '{CMD_READ,   8'd0,   16'd0,      1'b1, '{ST_NOT_FOUND, 16'd0, 8'h00}},
        '{CMD_START,  8'd255, 16'hFFFF,   1'b1, '{ST_OK, 16'd0, 8'h00}},
        '{CMD_READ,   8'd255, 16'd0,      1'b1, '{ST_OK, 16'hFFFF, 8'h00}},
        '{CMD_START,  8'd255, 16'd1,      1'b1, '{ST_OK, 16'd0, 8'h00}},
        '{CMD_START,  8'd1,   16'd1,      1'b1, '{ST_OK, 16'd0, 8'h00}},
        '{CMD_START,  8'd2,   16'd2,      1'b1, '{ST_OK, 16'd0, 8'h00}},
        '{CMD_START,  8'd3,   16'd3,      1'b1, '{ST_OK, 16'd0, 8'h00}},
        '{CMD_START,  8'd4,   16'd4,      1'b1, '{ST_OK, 16'd0, 8'h00}},
        '{CMD_START,  8'd5,   16'd5,      1'b1, '{ST_OK, 16'd0, 8'h00}},
        '{CMD_START,  8'd6,   16'd6,      1'b1, '{ST_OK, 16'd0, 8'h00}},
        '{CMD_START,  8'd7,   16'd7,      1'b1, '{ST_OK, 16'd0, 8'h00}},
        '{CMD_START,  8'd200, 16'h1234,   1'b1, '{ST_FULL, 16'd0, 8'h00}},
        '{CMD_READ,   8'd200, 16'd0,      1'b1, '{ST_NOT_FOUND, 16'd0, 8'h00}},
        '{CMD_TICK,   8'd0,   16'd0,      1'b0, '{ST_OK, 16'd0, 8'h00}},
        '{CMD_READ,   8'd3,   16'd0,      1'b0, '{ST_OK, 16'd0, 8'h00}},
        '{CMD_START,  8'd200, 16'hAAAA,   1'b0, '{ST_OK, 16'd0, 8'h00}},
        '{CMD_START,  8'h55,  16'h5555,   1'b0, '{ST_OK, 16'd0, 8'h00}},
        '{CMD_UNUSED, 8'hFF,  16'hFFFF,   1'b1, '{ST_OK, 16'd0, 8'h00}}
    };

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_in_valid   = 1'b0;
    logic                o_in_stall;
    logic [CMD_W-1:0]    i_command    = '0;
    logic [ID_W-1:0]     i_timer_id   = '0;
    logic [LOAD_W-1:0]   i_load_value = '0;
    logic                o_out_valid;
    logic                i_out_stall  = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [REM_W-1:0]    o_remaining;
    logic [MASK_W-1:0]   o_expired_mask;

    // predictor copy of the slot table
    logic                  slot_busy [SLOTS];
    logic [ID_W-1:0]       slot_tag  [SLOTS];
    logic [COUNT_BITS-1:0] slot_left [SLOTS];

    t_timer_reply pending_replies [$];
    int  mismatches = 0;
    bit  quiet_tail = 1'b0;
    bit  hold_output_request = 1'b0;

    // coverage tallies for the summary
    int n_items = 0, n_starts = 0, n_full = 0, n_ticks = 0, n_freed = 0;
    int n_reads = 0, n_misses = 0, n_unused = 0;

    countdown_timer_table_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_timer_id     (i_timer_id),
        .i_load_value   (i_load_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_remaining    (o_remaining),
        .o_expired_mask (o_expired_mask)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // apply one command to the predicted table and return the reply it gives
    function automatic t_timer_reply apply_timer_cmd(input logic [CMD_W-1:0] cmd,
                                                     input logic [ID_W-1:0] id,
                                                     input logic [LOAD_W-1:0] load);
        t_timer_reply r;
        int hit;
        int free_slot;
        r = '0;
        hit = -1;
        free_slot = -1;
        n_items++;
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_busy[i] && slot_tag[i] == id && hit < 0) hit = i;
            if (!slot_busy[i] && free_slot < 0) free_slot = i;
        end
        case (cmd)
            CMD_START: begin
                n_starts++;
                if (hit >= 0) begin
                    slot_left[hit] = load;
                end else if (free_slot >= 0) begin
                    slot_busy[free_slot] = 1'b1;
                    slot_tag[free_slot]  = id;
                    slot_left[free_slot] = load;
                end else begin
                    r.status = ST_FULL;
                    n_full++;
                end
            end
            CMD_TICK: begin
                n_ticks++;
                // a zero count frees at once, otherwise free when it hits zero
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_busy[i]) begin
                        if (slot_left[i] != '0) slot_left[i] = slot_left[i] - 1'b1;
                        if (slot_left[i] == '0) begin
                            slot_busy[i] = 1'b0;
                            n_freed++;
                            if (i < MASK_W) r.expired[i] = 1'b1;
                        end
                    end
                end
            end
            CMD_READ: begin
                n_reads++;
                if (hit >= 0) begin
                    r.remaining = slot_left[hit];
                end else begin
                    r.status = ST_NOT_FOUND;
                    n_misses++;
                end
            end
            default: n_unused++;
        endcase
        return r;
    endfunction

    // present one item and hold it until taken, then record its reply
    task automatic offer_item(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                              input logic [LOAD_W-1:0] load, input logic known,
                              input t_timer_reply typed_reply);
        t_timer_reply predicted;
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_timer_id   <= id;
        i_load_value <= load;
        do @(posedge i_clk); while (o_in_stall);
        predicted = apply_timer_cmd(cmd, id, load);
        pending_replies.push_back(known ? typed_reply : predicted);
    endtask

    // drop valid for a number of cycles
    task automatic idle_input(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // input side: reset, directed table, random traffic, final drain
    initial begin : in_side
        logic [CMD_W-1:0]  cmd;
        logic [ID_W-1:0]   id;
        logic [LOAD_W-1:0] load;
        int pick;
        for (int i = 0; i < SLOTS; i++) begin
            slot_busy[i] = 1'b0;
            slot_tag[i]  = '0;
            slot_left[i] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int r = 0; r < SCRIPT_LEN; r++) begin
            offer_item(SCRIPT[r].cmd, SCRIPT[r].id, SCRIPT[r].load, SCRIPT[r].known,
                       SCRIPT[r].reply);
            if ($urandom_range(0, 3) == 0) idle_input($urandom_range(1, 8));
        end

        // random traffic, mostly a small id pool and short counts so slots churn
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == PHASE_HOLD) hold_output_request = 1'b1;
            if (n == PHASE_DRAIN) begin
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (pending_replies.size() != 0);
            end
            if (n == PHASE_QUIET) quiet_tail = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 40)      cmd = CMD_START;
            else if (pick < 65) cmd = CMD_TICK;
            else if (pick < 95) cmd = CMD_READ;
            else                cmd = CMD_UNUSED;
            id   = ($urandom_range(0, 3) == 0) ? ID_W'($urandom_range(0, 255))
                                               : ID_W'($urandom_range(0, 11));
            load = ($urandom_range(0, 7) == 0) ? LOAD_W'($urandom_range(0, 65535))
                                               : LOAD_W'($urandom_range(0, 5));
            offer_item(cmd, id, load, 1'b0, '0);
            if (!quiet_tail && $urandom_range(0, 4) == 0) idle_input($urandom_range(1, 8));
        end

        // wait for the last replies, then for any stray one
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_replies.size() != 0);
        repeat (SETTLE) @(posedge i_clk);

        $display("covered %0d items: %0d starts (%0d full), %0d ticks freeing %0d slots,",
                 n_items, n_starts, n_full, n_ticks, n_freed);
        $display("%0d reads (%0d absent ids), %0d spare commands, %0d field mismatches",
                 n_reads, n_misses, n_unused, mismatches);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // output side stall: random bursts, one long hold, none in the tail
    initial begin : out_side
        forever begin
            @(posedge i_clk);
            if (hold_output_request) begin
                hold_output_request = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(posedge i_clk);
            end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(0, 7)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(0, 20)) @(posedge i_clk);
            end
        end
    end

    // compare each taken reply with the oldest expected one
    always @(posedge i_clk) begin
        t_timer_reply want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_replies.size() == 0) begin
                $display("%0t ns: reply with nothing expected, status %0d remaining %0d mask %h",
                         $time, o_status, o_remaining, o_expired_mask);
                mismatches++;
            end else begin
                want = pending_replies.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t ns: status expected %0d, actual %0d",
                             $time, want.status, o_status);
                    mismatches++;
                end
                if (o_remaining !== want.remaining) begin
                    $display("%0t ns: remaining expected %0d, actual %0d",
                             $time, want.remaining, o_remaining);
                    mismatches++;
                end
                if (o_expired_mask !== want.expired) begin
                    $display("%0t ns: expired_mask expected %h, actual %h",
                             $time, want.expired, o_expired_mask);
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    initial begin : watchdog
        #5_000_000;
        $display("timeout with %0d replies outstanding", pending_replies.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: files.f
design/ctt_pkg.sv
design/ctt_front.sv
design/ctt_back.sv
design/countdown_timer_table_core.sv
verif/tb_top.sv
